// File: src/srd_pkg.sv
// Shared types and constants for the shift register debouncer.
package srd_pkg;

  localparam int MaxHistory = 31;
  localparam int MinHistory = 3;
  localparam int HistW      = MaxHistory;
  localparam int LenW       = 5;
  localparam int IntervalW  = 20;
  localparam int TimeW      = 32;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = IntervalW;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 8;
  localparam logic [LenW-1:0] HistReset = LenW'(8);

  typedef enum logic [1:0] {
    PhUp       = 2'd0,
    PhDown     = 2'd1,
    PhPushed   = 2'd2,
    PhReleased = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ReqPoll  = 2'd0,
    ReqRead  = 2'd1,
    ReqStart = 2'd2
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInterval = 2'd0,
    CfgHistory  = 2'd1,
    CfgInvert   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [IntervalW-1:0] interval;
    logic [LenW-1:0]      hist_bits;
    logic                 invert;
  } cfg_t;

  typedef struct packed {
    logic [HistW-1:0] history;
    logic [TimeW-1:0] last_time;
    phase_e           phase;
    logic             pending;
    logic             running;
  } state_t;

  typedef struct packed {
    logic [1:0]       req;
    logic             pin;
    logic [TimeW-1:0] now;
  } item_t;

  typedef struct packed {
    logic   available;
    logic   level;
    phase_e phase;
  } result_t;

endpackage

// File: src/srd_core.sv
// Next-state and result logic for one debouncer item.
module srd_core (
  input  srd_pkg::cfg_t    cfg_i,
  input  srd_pkg::state_t  state_i,
  input  srd_pkg::item_t   item_i,
  output srd_pkg::state_t  state_o,
  output srd_pkg::result_t result_o
);

  logic [srd_pkg::LenW-1:0]  len;
  logic [31:0]               mask32;
  logic [31:0]               push32;
  logic [31:0]               rel32;
  logic [srd_pkg::HistW-1:0] mask;
  logic [srd_pkg::HistW-1:0] push_pat;
  logic [srd_pkg::HistW-1:0] rel_pat;
  logic [srd_pkg::HistW-1:0] shifted;
  logic [srd_pkg::TimeW-1:0] since;
  logic                      sample_bit;
  logic                      level;

  always_comb begin
    if (cfg_i.hist_bits < srd_pkg::LenW'(srd_pkg::MinHistory)) begin
      len = srd_pkg::LenW'(srd_pkg::MinHistory);
    end else if (cfg_i.hist_bits > srd_pkg::LenW'(srd_pkg::MaxHistory)) begin
      len = srd_pkg::LenW'(srd_pkg::MaxHistory);
    end else begin
      len = cfg_i.hist_bits;
    end
  end

  assign mask32     = (32'd1 << len) - 32'd1;
  assign push32     = 32'd1 << (len - srd_pkg::LenW'(1));
  assign rel32      = push32 - 32'd1;
  assign mask       = mask32[srd_pkg::HistW-1:0];
  assign push_pat   = push32[srd_pkg::HistW-1:0];
  assign rel_pat    = rel32[srd_pkg::HistW-1:0];
  assign sample_bit = ~item_i.pin ^ cfg_i.invert;
  assign shifted    = {state_i.history[srd_pkg::HistW-2:0], sample_bit} & mask;
  assign since      = item_i.now - srd_pkg::TimeW'(cfg_i.interval);

  always_comb begin
    state_o = state_i;
    level   = 1'b0;
    case (srd_pkg::req_e'(item_i.req))
      srd_pkg::ReqStart: begin
        state_o.running = 1'b1;
        if (item_i.pin) begin
          state_o.phase   = srd_pkg::PhDown;
          state_o.history = rel_pat;
        end else begin
          state_o.phase   = srd_pkg::PhUp;
          state_o.history = push_pat;
        end
      end
      srd_pkg::ReqPoll: begin
        if (state_i.running &&
            ((cfg_i.interval == '0) || (since > state_i.last_time))) begin
          if (cfg_i.interval != '0) begin
            state_o.last_time = item_i.now;
          end
          state_o.history = shifted;
          if (shifted == rel_pat) begin
            state_o.phase   = srd_pkg::PhReleased;
            state_o.pending = 1'b1;
          end else if (shifted == push_pat) begin
            state_o.phase   = srd_pkg::PhPushed;
            state_o.pending = 1'b1;
          end
        end
      end
      srd_pkg::ReqRead: begin
        state_o.pending = 1'b0;
        if (state_i.phase == srd_pkg::PhReleased) begin
          state_o.phase = srd_pkg::PhUp;
        end else if (state_i.phase == srd_pkg::PhPushed) begin
          state_o.phase = srd_pkg::PhDown;
        end
        level = (state_o.phase != srd_pkg::PhDown);
      end
      default: ;
    endcase
  end

  assign result_o.available = state_o.pending;
  assign result_o.level     = level;
  assign result_o.phase     = state_o.phase;

endmodule

// File: src/shift_register_debouncer_top.sv
// Top level of the shift register button debouncer.
//
// Items enter on the s_axis channel: tuser carries the request kind (poll,
// read and acknowledge, start), tdata the pin level and a microsecond
// timestamp. Each item yields exactly one result item on m_axis with the
// pending-event flag, the read level and the button phase.
// Registers are written through the cfg channel, always ready; the user must
// write them only while the block is idle, which the block does not enforce.
// An accepted item waits in the input register, where the shift, pattern
// compare and timer check are evaluated and the state updated as it moves
// to the output register; throughput is one item per cycle unless the
// receiver stalls. A stalled receiver holds the output register; the
// input register still takes one more item, then s_axis_tready drops.
// Reset clears the state (running off, phase up, history zero) and the
// registers to interval 0, history length 8, no inversion.
module shift_register_debouncer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [0] pin_level, [32:1] now_us, [39:33] zero
  input  logic [srd_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] available, [1] level, [3:2] button_phase, [7:4] zero
  output logic [srd_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [srd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [srd_pkg::CfgDataW-1:0] cfg_data_i
);

  srd_pkg::cfg_t    cfg_q;
  srd_pkg::state_t  state_q, state_d;
  srd_pkg::item_t   item_q;
  srd_pkg::result_t res_q, res_d;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  srd_core u_core (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval  <= '0;
      cfg_q.hist_bits <= srd_pkg::HistReset;
      cfg_q.invert    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (srd_pkg::cfg_idx_e'(cfg_index_i))
        srd_pkg::CfgInterval: cfg_q.interval  <= cfg_data_i;
        srd_pkg::CfgHistory:  cfg_q.hist_bits <= cfg_data_i[srd_pkg::LenW-1:0];
        srd_pkg::CfgInvert:   cfg_q.invert    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.req <= s_axis_tuser;
      item_q.pin <= s_axis_tdata[0];
      item_q.now <= s_axis_tdata[srd_pkg::TimeW:1];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, res_q.phase, res_q.level, res_q.available};

endmodule
